// ----- rtl/pie_pkg.sv -----
// Shared types, codes and helpers for the PageRank iteration engine.
// No dependencies; the other files that use it refer to it by scoped names.
package pie_pkg;

  localparam int unsigned SCORE_W   = 32;
  localparam int unsigned SCALED_W  = 42;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 17;
  localparam int unsigned DIV_NUM_W = 64;
  localparam int unsigned DIV_CNT_W = 7;

  localparam logic [OP_W-1:0] OP_LOAD = 3'd0;
  localparam logic [OP_W-1:0] OP_LINK = 3'd1;
  localparam logic [OP_W-1:0] OP_ITER = 3'd2;
  localparam logic [OP_W-1:0] OP_READ = 3'd3;
  localparam logic [OP_W-1:0] OP_EVEN = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANK_MODE  = 2'd2;

  localparam logic [10:0] NODE_COUNT_RST = 11'd1;
  localparam logic [16:0] DAMPING_RST    = 17'd52429;
  localparam logic [16:0] DAMPING_ONE    = 17'd65536;

  // dividend lengths in bits, numerator left-aligned in DIV_NUM_W
  localparam logic [DIV_CNT_W-1:0] LEN_EVEN  = 7'd31;
  localparam logic [DIV_CNT_W-1:0] LEN_BASE  = 7'd31;
  localparam logic [DIV_CNT_W-1:0] LEN_DANG  = 7'd32;
  localparam logic [DIV_CNT_W-1:0] LEN_SHARE = 7'd33;
  localparam logic [DIV_CNT_W-1:0] LEN_NORM  = 7'd62;

  typedef enum logic [1:0] {
    ST_OK,
    ST_RANGE,
    ST_FULL
  } status_e;

  function automatic logic [SCORE_W-1:0] sat_score(input logic [34:0] x);
    logic [SCORE_W-1:0] r;
    r = (x[34:32] != 3'd0) ? '1 : x[31:0];
    return r;
  endfunction

endpackage

// ----- rtl/pie_if.sv -----
// Channel interfaces of the PageRank iteration engine: input items, results, config writes.
// Depends on pie_pkg for field widths.
interface pie_in_if;
  logic                          valid;
  logic                          ready;
  logic [pie_pkg::OP_W-1:0]      operation;
  logic [pie_pkg::IDX_W-1:0]     node_index;
  logic [pie_pkg::IDX_W-1:0]     target_index;
  logic [pie_pkg::SCORE_W-1:0]   score_in;
  modport source (output valid, operation, node_index, target_index, score_in, input ready);
  modport sink   (input valid, operation, node_index, target_index, score_in, output ready);
endinterface

interface pie_out_if;
  logic                          valid;
  logic                          ready;
  logic [pie_pkg::SCORE_W-1:0]   score_out;
  logic [pie_pkg::SCALED_W-1:0]  scaled_score;
  logic [1:0]                    status;
  modport source (output valid, score_out, scaled_score, status, input ready);
  modport sink   (input valid, score_out, scaled_score, status, output ready);
endinterface

interface pie_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pie_pkg::CFG_IDX_W-1:0]   index;
  logic [pie_pkg::CFG_DAT_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/pagerank_iteration_engine_unit.sv -----
// PageRank iteration engine top: sequencer over score, next-score, degree and link RAMs.
// Depends on pie_pkg, pie_if, pie_ram, pie_div. One item at a time: the next is taken once
// the result is registered. Set even: a 31-bit divide, then N writes. Iterate: base divide,
// next scores zeroed; rank mode off: 32-bit divide per dangling node, 33-bit per link, final
// pass; rank mode on: no link divide, sum pass, 62-bit divide per node (none if the sum is 0).
// After reset a clearing pass zeroes scores and degrees; no item taken.
module pagerank_iteration_engine_unit #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_LINKS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pie_in_if.sink      in_if,
  pie_cfg_if.sink     cfg_if,
  pie_out_if.source   out_if
);

  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned NCW = $clog2(MAX_NODES + 1);
  localparam int unsigned LAW = $clog2(MAX_LINKS);
  localparam int unsigned LTW = $clog2(MAX_LINKS + 1);
  localparam int unsigned TW  = 32 + NW;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD_WAIT, S_LINK_DEG, S_EVEN_DIV, S_EVEN_WR,
    S_IT_BASE, S_IT_ZERO, S_DG_RD, S_DG_CHK, S_DG_DIV,
    S_LK_RD, S_LK_CHK, S_LK_MUL, S_LK_DIV, S_LK_WAIT, S_LK_WR,
    S_FN_RD, S_FN_WR, S_VS_RD, S_VS_WR, S_NM_RD, S_NM_DIV, S_NM_WAIT, S_NM_WR,
    S_RESP
  } state_e;

  state_e             state_q;
  logic [10:0]        node_count_q;
  logic [16:0]        damping_q;
  logic               rank_mode_q;
  logic [NCW-1:0]     n_eff;
  logic [16:0]        d_eff;

  logic [NW-1:0]      clr_q, lsrc_q, ldst_q, tgt_q;
  logic [NCW-1:0]     idx_q;
  logic [LTW-1:0]     lk_q, total_q, deg_q;
  logic [33:0]        base_q, share_q;
  logic [31:0]        even_q, norm_q, nxv_q;
  logic [48:0]        prod_q;
  logic [TW-1:0]      sum_q;

  logic [31:0]        res_score_q, out_score_q;
  logic [41:0]        res_scaled_q, out_scaled_q;
  pie_pkg::status_e   res_status_q, out_status_q;
  logic               out_valid_q;

  logic               div_start_q, div_busy, div_done;
  logic [63:0]        div_num_q, div_quo;
  logic [TW-1:0]      div_den_q;
  logic [6:0]         div_len_q;

  logic               sc_we, sc_re, nx_we, nx_re, dg_we, dg_re, lk_we, lk_re;
  logic [NW-1:0]      sc_waddr, sc_raddr, nx_waddr, nx_raddr, dg_waddr, dg_raddr;
  logic [31:0]        sc_wdata, sc_rdata, nx_wdata, nx_rdata;
  logic [LTW-1:0]     dg_wdata, dg_rdata;
  logic [LAW-1:0]     lk_waddr, lk_raddr;
  logic [2*NW-1:0]    lk_wdata, lk_rdata;

  logic               in_accept, a_ok, b_ok, lk_ok, idx_last, lk_last, full;
  logic [NW-1:0]      a_addr, b_addr, lk_src, lk_dst;
  logic [31:0]        fn_sum, lk_sum;
  logic [31+NCW:0]    scaled_full;
  logic [48:0]        prod_full;
  state_e             links_entry, post_entry;

  always_comb begin
    if (node_count_q == 11'd0) begin
      n_eff = NCW'(1);
    end else if (32'(node_count_q) > MAX_NODES) begin
      n_eff = NCW'(MAX_NODES);
    end else begin
      n_eff = NCW'(node_count_q);
    end
  end

  assign d_eff       = (damping_q > pie_pkg::DAMPING_ONE) ? pie_pkg::DAMPING_ONE : damping_q;
  assign in_if.ready = (state_q == S_IDLE);
  assign in_accept   = in_if.valid && in_if.ready;
  assign a_ok        = 32'(in_if.node_index) < 32'(n_eff);
  assign b_ok        = 32'(in_if.target_index) < 32'(n_eff);
  assign a_addr      = NW'(in_if.node_index);
  assign b_addr      = NW'(in_if.target_index);
  assign lk_src      = lk_rdata[2*NW-1:NW];
  assign lk_dst      = lk_rdata[NW-1:0];
  assign lk_ok       = (32'(lk_src) < 32'(n_eff)) && (32'(lk_dst) < 32'(n_eff));
  assign idx_last    = idx_q == (n_eff - NCW'(1));
  assign lk_last     = lk_q == (total_q - LTW'(1));
  assign full        = total_q == LTW'(MAX_LINKS);
  assign fn_sum      = pie_pkg::sat_score({3'd0, nx_rdata} + {1'b0, base_q});
  assign lk_sum      = pie_pkg::sat_score({3'd0, nxv_q} + {1'b0, share_q});
  assign scaled_full = sc_rdata * n_eff;
  assign prod_full   = sc_rdata * d_eff;
  assign post_entry  = rank_mode_q ? S_VS_RD : S_FN_RD;
  assign links_entry = (total_q == '0) ? post_entry : S_LK_RD;
  assign cfg_if.ready = 1'b1;

  // RAM port control
  always_comb begin
    sc_we = 1'b0; sc_re = 1'b0; nx_we = 1'b0; nx_re = 1'b0;
    dg_we = 1'b0; dg_re = 1'b0; lk_we = 1'b0; lk_re = 1'b0;
    sc_waddr = idx_q[NW-1:0]; sc_raddr = idx_q[NW-1:0]; sc_wdata = '0;
    nx_waddr = idx_q[NW-1:0]; nx_raddr = idx_q[NW-1:0]; nx_wdata = '0;
    dg_waddr = lsrc_q; dg_raddr = idx_q[NW-1:0]; dg_wdata = '0;
    lk_waddr = total_q[LAW-1:0]; lk_raddr = lk_q[LAW-1:0]; lk_wdata = {lsrc_q, ldst_q};
    case (state_q)
      S_CLEAR: begin
        sc_we = 1'b1; sc_waddr = clr_q;
        dg_we = 1'b1; dg_waddr = clr_q;
      end
      S_IDLE: begin
        if (in_accept && a_ok) begin
          if (in_if.operation == pie_pkg::OP_LOAD) begin
            sc_we = 1'b1; sc_waddr = a_addr; sc_wdata = in_if.score_in;
          end else if (in_if.operation == pie_pkg::OP_READ) begin
            sc_re = 1'b1; sc_raddr = a_addr;
          end else if (in_if.operation == pie_pkg::OP_LINK && b_ok && !full) begin
            dg_re = 1'b1; dg_raddr = a_addr;
          end
        end
      end
      S_LINK_DEG: begin
        dg_we = 1'b1; dg_wdata = dg_rdata + LTW'(1);
        lk_we = 1'b1;
      end
      S_EVEN_WR: begin
        sc_we = 1'b1; sc_wdata = even_q;
      end
      S_IT_ZERO: nx_we = 1'b1;
      S_DG_RD: begin
        sc_re = 1'b1; dg_re = 1'b1;
      end
      S_LK_RD: lk_re = 1'b1;
      S_LK_CHK: begin
        if (lk_ok) begin
          sc_re = 1'b1; sc_raddr = lk_src;
          dg_re = 1'b1; dg_raddr = lk_src;
          nx_re = 1'b1; nx_raddr = lk_dst;
        end
      end
      S_LK_WR: begin
        nx_we = 1'b1; nx_waddr = tgt_q; nx_wdata = lk_sum;
      end
      S_FN_RD, S_VS_RD, S_NM_RD: nx_re = 1'b1;
      S_FN_WR: begin
        sc_we = 1'b1; sc_wdata = fn_sum;
      end
      S_VS_WR: begin
        nx_we = 1'b1; nx_wdata = fn_sum;
      end
      S_NM_WR: begin
        sc_we = 1'b1; sc_wdata = norm_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      node_count_q <= pie_pkg::NODE_COUNT_RST;
      damping_q    <= pie_pkg::DAMPING_RST;
      rank_mode_q  <= 1'b0;
      clr_q        <= '0;
      lsrc_q       <= '0;
      ldst_q       <= '0;
      tgt_q        <= '0;
      idx_q        <= '0;
      lk_q         <= '0;
      total_q      <= '0;
      deg_q        <= '0;
      base_q       <= '0;
      share_q      <= '0;
      even_q       <= '0;
      norm_q       <= '0;
      nxv_q        <= '0;
      prod_q       <= '0;
      sum_q        <= '0;
      res_score_q  <= '0;
      res_scaled_q <= '0;
      res_status_q <= pie_pkg::ST_OK;
      out_valid_q  <= 1'b0;
      out_score_q  <= '0;
      out_scaled_q <= '0;
      out_status_q <= pie_pkg::ST_OK;
      div_start_q  <= 1'b0;
      div_num_q    <= '0;
      div_den_q    <= '0;
      div_len_q    <= '0;
    end else begin
      div_start_q <= 1'b0;
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          pie_pkg::CFG_NODE_COUNT: node_count_q <= cfg_if.data[10:0];
          pie_pkg::CFG_DAMPING:    damping_q    <= cfg_if.data;
          pie_pkg::CFG_RANK_MODE:  rank_mode_q  <= cfg_if.data[0];
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + NW'(1);
          if (clr_q == NW'(MAX_NODES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            res_score_q  <= '0;
            res_scaled_q <= '0;
            res_status_q <= pie_pkg::ST_OK;
            lsrc_q       <= a_addr;
            ldst_q       <= b_addr;
            idx_q        <= '0;
            state_q      <= S_RESP;
            case (in_if.operation)
              pie_pkg::OP_LOAD: begin
                if (!a_ok) res_status_q <= pie_pkg::ST_RANGE;
              end
              pie_pkg::OP_LINK: begin
                if (!a_ok || !b_ok) begin
                  res_status_q <= pie_pkg::ST_RANGE;
                end else if (full) begin
                  res_status_q <= pie_pkg::ST_FULL;
                end else begin
                  state_q <= S_LINK_DEG;
                end
              end
              pie_pkg::OP_READ: begin
                if (!a_ok) begin
                  res_status_q <= pie_pkg::ST_RANGE;
                end else begin
                  state_q <= S_RD_WAIT;
                end
              end
              pie_pkg::OP_EVEN: begin
                div_start_q <= 1'b1;
                div_num_q   <= {1'b1, 63'd0};
                div_den_q   <= TW'(n_eff);
                div_len_q   <= pie_pkg::LEN_EVEN;
                state_q     <= S_EVEN_DIV;
              end
              pie_pkg::OP_ITER: begin
                div_start_q <= 1'b1;
                div_num_q   <= {pie_pkg::DAMPING_ONE - d_eff, 14'd0, 33'd0};
                div_den_q   <= TW'(n_eff);
                div_len_q   <= pie_pkg::LEN_BASE;
                state_q     <= S_IT_BASE;
              end
              default: ;
            endcase
          end
        end
        S_RD_WAIT: begin
          res_score_q  <= sc_rdata;
          res_scaled_q <= 42'(scaled_full);
          state_q      <= S_RESP;
        end
        S_LINK_DEG: begin
          total_q <= total_q + LTW'(1);
          state_q <= S_RESP;
        end
        S_EVEN_DIV: begin
          if (div_done) begin
            even_q  <= div_quo[31:0];
            state_q <= S_EVEN_WR;
          end
        end
        S_EVEN_WR: begin
          idx_q <= idx_q + NCW'(1);
          if (idx_last) state_q <= S_RESP;
        end
        S_IT_BASE: begin
          if (div_done) begin
            base_q  <= div_quo[33:0];
            state_q <= S_IT_ZERO;
          end
        end
        S_IT_ZERO: begin
          if (idx_last) begin
            idx_q   <= '0;
            lk_q    <= '0;
            sum_q   <= '0;
            state_q <= rank_mode_q ? links_entry : S_DG_RD;
          end else begin
            idx_q <= idx_q + NCW'(1);
          end
        end
        S_DG_RD: state_q <= S_DG_CHK;
        S_DG_CHK, S_DG_DIV: begin
          if (state_q == S_DG_CHK && dg_rdata == '0) begin
            div_start_q <= 1'b1;
            div_num_q   <= {sc_rdata, 32'd0};
            div_den_q   <= TW'(n_eff);
            div_len_q   <= pie_pkg::LEN_DANG;
            state_q     <= S_DG_DIV;
          end else if (state_q == S_DG_CHK || div_done) begin
            if (state_q == S_DG_DIV) base_q <= base_q + div_quo[33:0];
            if (idx_last) begin
              idx_q   <= '0;
              state_q <= links_entry;
            end else begin
              idx_q   <= idx_q + NCW'(1);
              state_q <= S_DG_RD;
            end
          end
        end
        S_LK_RD: state_q <= S_LK_CHK;
        S_LK_CHK, S_LK_MUL, S_LK_WR: begin
          if (state_q == S_LK_CHK && lk_ok) begin
            tgt_q   <= lk_dst;
            state_q <= S_LK_MUL;
          end else if (state_q == S_LK_MUL && dg_rdata != '0) begin
            prod_q  <= prod_full;
            nxv_q   <= nx_rdata;
            deg_q   <= dg_rdata;
            state_q <= S_LK_DIV;
          end else if (lk_last) begin
            idx_q   <= '0;
            state_q <= post_entry;
          end else begin
            lk_q    <= lk_q + LTW'(1);
            state_q <= S_LK_RD;
          end
        end
        S_LK_DIV: begin
          if (!rank_mode_q) begin
            div_start_q <= 1'b1;
            div_num_q   <= {prod_q[48:16], 31'd0};
            div_den_q   <= TW'(deg_q);
            div_len_q   <= pie_pkg::LEN_SHARE;
            state_q     <= S_LK_WAIT;
          end else begin
            share_q <= {1'b0, prod_q[48:16]};
            state_q <= S_LK_WR;
          end
        end
        S_LK_WAIT: begin
          if (div_done) begin
            share_q <= div_quo[33:0];
            state_q <= S_LK_WR;
          end
        end
        S_FN_RD: state_q <= S_FN_WR;
        S_FN_WR: begin
          idx_q <= idx_q + NCW'(1);
          state_q <= idx_last ? S_RESP : S_FN_RD;
        end
        S_VS_RD: state_q <= S_VS_WR;
        S_VS_WR: begin
          sum_q <= sum_q + TW'(fn_sum);
          if (idx_last) begin
            idx_q   <= '0;
            state_q <= S_NM_RD;
          end else begin
            idx_q   <= idx_q + NCW'(1);
            state_q <= S_VS_RD;
          end
        end
        S_NM_RD: state_q <= S_NM_DIV;
        S_NM_DIV: begin
          if (sum_q == '0) begin
            norm_q  <= '0;
            state_q <= S_NM_WR;
          end else begin
            div_start_q <= 1'b1;
            div_num_q   <= {nx_rdata, 32'd0};
            div_den_q   <= sum_q;
            div_len_q   <= pie_pkg::LEN_NORM;
            state_q     <= S_NM_WAIT;
          end
        end
        S_NM_WAIT: begin
          if (div_done) begin
            norm_q  <= div_quo[31:0];
            state_q <= S_NM_WR;
          end
        end
        S_NM_WR: begin
          idx_q <= idx_q + NCW'(1);
          state_q <= idx_last ? S_RESP : S_NM_RD;
        end
        S_RESP: begin
          if (!out_valid_q || out_if.ready) begin
            out_valid_q  <= 1'b1;
            out_score_q  <= res_score_q;
            out_scaled_q <= res_scaled_q;
            out_status_q <= res_status_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  pie_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_scores (
    .clk_i, .we_i(sc_we), .waddr_i(sc_waddr), .wdata_i(sc_wdata),
    .re_i(sc_re), .raddr_i(sc_raddr), .rdata_o(sc_rdata)
  );

  pie_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .re_i(nx_re), .raddr_i(nx_raddr), .rdata_o(nx_rdata)
  );

  pie_ram #(.WIDTH(LTW), .DEPTH(MAX_NODES)) u_degree (
    .clk_i, .we_i(dg_we), .waddr_i(dg_waddr), .wdata_i(dg_wdata),
    .re_i(dg_re), .raddr_i(dg_raddr), .rdata_o(dg_rdata)
  );

  pie_ram #(.WIDTH(2*NW), .DEPTH(MAX_LINKS)) u_links (
    .clk_i, .we_i(lk_we), .waddr_i(lk_waddr), .wdata_i(lk_wdata),
    .re_i(lk_re), .raddr_i(lk_raddr), .rdata_o(lk_rdata)
  );

  pie_div #(.DEN_W(TW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start_q), .num_i(div_num_q), .den_i(div_den_q),
    .len_i(div_len_q), .busy_o(div_busy), .done_o(div_done), .quo_o(div_quo)
  );

  assign out_if.valid        = out_valid_q;
  assign out_if.score_out    = out_score_q;
  assign out_if.scaled_score = out_scaled_q;
  assign out_if.status       = out_status_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= LTW'(MAX_LINKS))
    else $error("link count beyond store size");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> !div_busy)
    else $error("divider started while busy");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_if.ready)
    else $error("second item taken before first finished");

  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && out_valid_q && !out_if.ready) |=> state_q == S_RESP)
    else $error("result dropped while output stalled");

endmodule

// ----- rtl/pie_ram.sv -----
// Simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module pie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pie_div.sv -----
// Restoring divider, one quotient bit per cycle, dividend left-aligned with a given length.
// Depends on pie_pkg for the dividend and counter widths.
module pie_div #(
  parameter int unsigned DEN_W = 42
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [pie_pkg::DIV_NUM_W-1:0]   num_i,
  input  logic [DEN_W-1:0]                den_i,
  input  logic [pie_pkg::DIV_CNT_W-1:0]   len_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [pie_pkg::DIV_NUM_W-1:0]   quo_o
);

  localparam int unsigned NUM_W = pie_pkg::DIV_NUM_W;

  logic                           busy_q, done_q;
  logic [pie_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic [NUM_W-1:0]               num_q, quo_q;
  logic [DEN_W-1:0]               den_q, rem_q;
  logic [DEN_W:0]                 trial, diff;
  logic                           ge;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= len_i;
        num_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        quo_q  <= '0;
      end else if (busy_q) begin
        num_q <= {num_q[NUM_W-2:0], 1'b0};
        rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
